### src/irps_pkg.sv
// Package for the indexed random-pick set.
// Holds sizes, action and status codes and the sequencer state type.
// No dependencies.
package irps_pkg;

	localparam int MAX_INDICES = 1024;
	localparam int IDX_W       = $clog2(MAX_INDICES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int RND_W       = 16;
	localparam int PROD_W      = CNT_W + RND_W;
	localparam int IN_W        = 32;
	localparam int OUT_W       = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_TAKE   = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_RANGE  = 3'd1,
		STAT_DUP    = 3'd2,
		STAT_ABSENT = 3'd3,
		STAT_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_PICK,
		S_WRITE
	} state_t;

endpackage

### src/indexed_random_pick_set.sv
// Top level of the indexed random-pick set: sequencer, slot tables, presence map.
// Depends on irps_pkg.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: index, random_value; tuser: action
// m_axis    out  m_axis_tvalid/tready       tdata: status, taken_index, was_present,
//                                           count_after, is_empty
// cfg       in   cfg_valid/cfg_ready        cfg_data: capacity
//
// A transaction runs through the steps accept, table look-up with the count * random
// product, slot pick read and write-back; the single read port of the slot table sets this.
// After reset all 1024 entries of the presence map are swept clear; s_axis_tready stays low.
// A result waiting in the output register holds the write-back step until taken.
module indexed_random_pick_set
	import irps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [9:0] index, [25:10] random_value, [31:26] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [2:0] status, [12:3] taken_index, [13] was_present, [24:14] count_after,
	// [25] is_empty, [31:26] zero
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   clr_q;
	logic [CNT_W-1:0]   cap_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	action_t            act_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RND_W-1:0]   rnd_q;
	logic               inr_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   last_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic [IDX_W-1:0]   slot_entries_q [MAX_INDICES];
	logic [IDX_W-1:0]   slot_of_index_q [MAX_INDICES];
	logic               present_q [MAX_INDICES];
	logic [IDX_W-1:0]   se_rd_q;
	logic [IDX_W-1:0]   soi_rd_q;
	logic               pres_rd_q;

	logic               se_re, se_we, soi_we, pres_we, look_re;
	logic [IDX_W-1:0]   se_raddr, se_waddr, se_wdata;
	logic [IDX_W-1:0]   soi_waddr, soi_wdata, pres_waddr;
	logic               pres_wdata;

	logic               accept, fire, out_free;
	logic [CNT_W-1:0]   usable_cap;
	logic               in_range;
	logic [PROD_W-1:0]  prod;
	logic [IDX_W-1:0]   last_addr;
	logic               present;
	status_t            stat;
	logic [IDX_W-1:0]   taken;

	assign cfg_ready     = 1'b1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign usable_cap    = (cap_q > CNT_W'(MAX_INDICES)) ? CNT_W'(MAX_INDICES) : cap_q;
	assign in_range      = {1'b0, s_axis_tdata[IDX_W-1:0]} < usable_cap;
	assign prod          = PROD_W'(cnt_q) * PROD_W'(rnd_q);
	assign last_addr     = IDX_W'(cnt_q - CNT_W'(1));
	assign present       = inr_q && pres_rd_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		fire          = 1'b0;
		look_re       = 1'b0;
		se_re         = 1'b0;
		se_raddr      = last_addr;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == {IDX_W{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				look_re  = 1'b1;
				se_re    = 1'b1;
				se_raddr = last_addr;
				state_d  = S_PICK;
			end
			S_PICK: begin
				se_re    = 1'b1;
				se_raddr = k_q;
				state_d  = S_WRITE;
			end
			S_WRITE: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		stat       = STAT_OK;
		taken      = '0;
		cnt_d      = cnt_q;
		se_we      = 1'b0;
		se_waddr   = se_rd_q;
		se_wdata   = last_q;
		soi_we     = 1'b0;
		soi_waddr  = last_q;
		soi_wdata  = soi_rd_q;
		pres_we    = 1'b0;
		pres_waddr = idx_q;
		pres_wdata = 1'b0;
		unique case (act_q)
			ACT_INSERT: begin
				if (!inr_q) begin
					stat = STAT_RANGE;
				end else if (present) begin
					stat = STAT_DUP;
				end else begin
					cnt_d      = cnt_q + CNT_W'(1);
					se_we      = 1'b1;
					se_waddr   = IDX_W'(cnt_q);
					se_wdata   = idx_q;
					soi_we     = 1'b1;
					soi_waddr  = idx_q;
					soi_wdata  = IDX_W'(cnt_q);
					pres_we    = 1'b1;
					pres_wdata = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!inr_q) begin
					stat = STAT_RANGE;
				end else if (!present) begin
					stat = STAT_ABSENT;
				end else begin
					cnt_d     = cnt_q - CNT_W'(1);
					se_we     = 1'b1;
					se_waddr  = soi_rd_q;
					soi_we    = 1'b1;
					soi_wdata = soi_rd_q;
					pres_we   = 1'b1;
				end
			end
			ACT_TAKE: begin
				if (cnt_q == '0) begin
					stat = STAT_EMPTY;
				end else begin
					taken      = se_rd_q;
					cnt_d      = cnt_q - CNT_W'(1);
					se_we      = 1'b1;
					se_waddr   = k_q;
					soi_we     = 1'b1;
					soi_wdata  = k_q;
					pres_we    = 1'b1;
					pres_waddr = se_rd_q;
				end
			end
			ACT_QUERY: begin
				if (!inr_q) begin
					stat = STAT_RANGE;
				end
			end
			default: stat = STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cap_q       <= CNT_W'(MAX_INDICES);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (fire) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(s_axis_tuser);
			idx_q <= s_axis_tdata[IDX_W-1:0];
			rnd_q <= s_axis_tdata[IDX_W+RND_W-1:IDX_W];
			inr_q <= in_range;
		end
		if (look_re) begin
			k_q <= prod[RND_W+IDX_W-1:RND_W];
		end
		if (state_q == S_PICK) begin
			last_q <= se_rd_q;
		end
		if (fire) begin
			out_data_q <= {6'd0, (cnt_d == '0), cnt_d, present, taken, stat};
		end
	end

	always_ff @(posedge clk) begin
		if (fire && se_we) begin
			slot_entries_q[se_waddr] <= se_wdata;
		end
		if (se_re) begin
			se_rd_q <= slot_entries_q[se_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (fire && soi_we) begin
			slot_of_index_q[soi_waddr] <= soi_wdata;
		end
		if (look_re) begin
			soi_rd_q <= slot_of_index_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			present_q[clr_q] <= 1'b0;
		end else if (fire && pres_we) begin
			present_q[pres_waddr] <= pres_wdata;
		end
		if (look_re) begin
			pres_rd_q <= present_q[idx_q];
		end
	end

endmodule

### src/irps_checker.sv
// Port-level checker for the indexed random-pick set, bound to the top level.
// Depends on irps_pkg and indexed_random_pick_set.
module irps_checker
	import irps_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[24:14] <= 11'(MAX_INDICES))
		else $error("count above maximum");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25] == (m_axis_tdata[24:14] == 11'd0))
		else $error("empty flag disagrees with count");

	a_taken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != STAT_OK |-> m_axis_tdata[12:3] == 10'd0)
		else $error("taken index set on failed transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

endmodule

bind indexed_random_pick_set irps_checker u_irps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
